// ===== rtl/core/sasc_pkg.sv =====
// ----------------------------------------------------------------------------
// Solar array slew controller package
// Shared types, command and register codes, constants and the pulse width
// function used by the slew controller modules.
// ----------------------------------------------------------------------------
package sasc_pkg;

    // Command codes carried in the command field of an input transaction.
    typedef enum logic [3:0] {
        CMD_TICK           = 4'd0,
        CMD_MANUAL_ANGLE   = 4'd1,
        CMD_CLEAR_OVERRIDE = 4'd2,
        CMD_STABLE_NEEDED  = 4'd3,
        CMD_IS_STABLE      = 4'd4,
        CMD_ATTITUDE       = 4'd5,
        CMD_SUN_OFFSET     = 4'd6,
        CMD_MODE           = 4'd7,
        CMD_FORBID         = 4'd8
    } cmd_t;

    // Array status as reported in the result.
    typedef enum logic [1:0] {
        STATUS_RETRACTED = 2'd0,
        STATUS_AT_REST   = 2'd1,
        STATUS_MOVING    = 2'd2
    } status_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SLEW_STEP         = 2'd0,
        CFG_ARRIVAL_THRESHOLD = 2'd1,
        CFG_ANGLE_LIMIT       = 2'd2
    } cfg_index_t;

    localparam int CfgIndexW = 2;
    localparam int CfgDataW  = 15;

    // Configuration reset values.
    localparam logic [10:0] SLEW_STEP_RESET         = 11'd100;
    localparam logic [9:0]  ARRIVAL_THRESHOLD_RESET = 10'd100;
    localparam logic [14:0] ANGLE_LIMIT_RESET       = 15'd8500;

    // Mode and submode pair that deploys the array.
    localparam logic [3:0] DEPLOY_MODE    = 4'd7;
    localparam logic [3:0] DEPLOY_SUBMODE = 4'd1;

    // Angle arithmetic constants, all in centidegrees, 18 bit signed.
    localparam logic signed [17:0] HALF_TURN   = 18'sd18000;
    localparam logic signed [17:0] FULL_TURN   = 18'sd36000;
    localparam logic signed [17:0] ANGLE_MAX   = 18'sd32767;
    localparam logic signed [17:0] ANGLE_MIN   = -18'sd32768;

    // Pulse width: floor(1500 + a/9) = floor((13500 + a)/9). The division by
    // nine is a multiply by ceil(2^19/9) and a shift, exact for numerators
    // below 65536.
    localparam logic signed [17:0] PULSE_BIAS        = 18'sd13500;
    localparam logic signed [15:0] SECOND_PANEL_SKEW = 16'sd500;
    localparam logic signed [15:0] FIRST_PANEL_SKEW  = 16'sd0;
    localparam logic [31:0]        DIV9_MULT         = 32'd58255;
    localparam logic [12:0]        PULSE_MAX         = 13'd4095;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [15:0] angle_value;
        logic               flag_value;
        logic [3:0]         mode_value;
        logic [3:0]         submode_value;
    } item_t;

    typedef struct packed {
        logic [10:0] slew_step;
        logic [9:0]  arrival_threshold;
        logic [14:0] angle_limit;
    } cfg_t;

    // State seen by the result stage after an update.
    typedef struct packed {
        logic signed [15:0] angle;
        status_t            status;
        logic               override_active;
    } view_t;

    function automatic logic [11:0] pulse_width(input logic signed [15:0] angle,
                                                input logic signed [15:0] skew);
        logic signed [17:0] v;
        logic [31:0]        prod;
        logic [12:0]        q;
        v    = PULSE_BIAS + 18'(angle) - 18'(skew);
        prod = 32'(v[15:0]) * DIV9_MULT;
        q    = prod[31:19];
        if (v < 18'sd0)
        begin
            pulse_width = 12'd0;
        end
        else if (q > PULSE_MAX)
        begin
            pulse_width = PULSE_MAX[11:0];
        end
        else
        begin
            pulse_width = q[11:0];
        end
    endfunction

endpackage

// ===== rtl/core/sasc_item_if.sv =====
// ----------------------------------------------------------------------------
// Slew controller input channel
// Valid/ready channel that carries one command transaction.
// ----------------------------------------------------------------------------
interface sasc_item_if;
    logic               valid;
    logic               ready;
    logic [3:0]         command;
    logic signed [15:0] angle_value;
    logic               flag_value;
    logic [3:0]         mode_value;
    logic [3:0]         submode_value;

    modport source (
        output valid, command, angle_value, flag_value, mode_value, submode_value,
        input  ready
    );
    modport sink (
        input  valid, command, angle_value, flag_value, mode_value, submode_value,
        output ready
    );
endinterface

// ===== rtl/core/sasc_result_if.sv =====
// ----------------------------------------------------------------------------
// Slew controller result channel
// Valid/ready channel that carries the pulse widths and array state.
// ----------------------------------------------------------------------------
interface sasc_result_if;
    logic               valid;
    logic               ready;
    logic [11:0]        pwm_first;
    logic [11:0]        pwm_second;
    logic [1:0]         array_status;
    logic signed [15:0] angle_now;
    logic               override_active;

    modport source (
        output valid, pwm_first, pwm_second, array_status, angle_now, override_active,
        input  ready
    );
    modport sink (
        input  valid, pwm_first, pwm_second, array_status, angle_now, override_active,
        output ready
    );
endinterface

// ===== rtl/core/sasc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Slew controller configuration channel
// Valid/ready write channel with a register index and write data.
// ----------------------------------------------------------------------------
interface sasc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sasc_pkg::CfgIndexW-1:0]  index;
    logic [sasc_pkg::CfgDataW-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/solar_array_slew_controller.sv =====
// ----------------------------------------------------------------------------
// Solar array slew controller
// Servo slew controller for two solar array panels. Each input transaction
// carries one command; each produces exactly one result transaction with the
// two servo pulse widths and the array state after the command.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake      Payload
//  -------  ---------  -------------  -------------------------------------------
//  item     in         valid / ready  command, angle_value, flag_value,
//                                     mode_value, submode_value
//  result   out        valid / ready  pwm_first, pwm_second, array_status,
//                                     angle_now, override_active
//  cfg      in         valid / ready  index, data (slew step, threshold, limit)
//
//  One transaction per cycle is sustained while the result channel is not
//  stalled. A command is latched in the input register, then the state update
//  and the pulse width multiply run combinationally into the result register.
//  Reset (rst_n low, asynchronous) retracts the array, clears all flags,
//  angles and the sun offset, and loads the configuration reset values.
//  A stall on the result channel holds the result register; the input
//  register keeps accepting while it is empty or moving on in the same cycle.
//  The configuration port is always ready and its writes take effect on the
//  next command.
// ----------------------------------------------------------------------------
module solar_array_slew_controller (
    input  logic           clk,
    input  logic           rst_n,
    sasc_item_if.sink      item,
    sasc_result_if.source  result,
    sasc_cfg_if.sink       cfg
);

    // Input register: one command waits here for the state update.
    logic             in_valid_reg;
    sasc_pkg::item_t  in_item_reg;

    sasc_pkg::cfg_t   cfg_values;
    sasc_pkg::view_t  view_next;
    logic             slot_free;
    logic             advance;

    // The held command moves on whenever the result register can take its
    // result; the state registers update in that same cycle, so commands are
    // applied strictly in order.
    assign advance    = in_valid_reg && slot_free;
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg.command       <= item.command;
            in_item_reg.angle_value   <= item.angle_value;
            in_item_reg.flag_value    <= item.flag_value;
            in_item_reg.mode_value    <= item.mode_value;
            in_item_reg.submode_value <= item.submode_value;
        end
    end

    sasc_cfg_regs u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_values (cfg_values)
    );

    sasc_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (advance),
        .item_q     (in_item_reg),
        .cfg_values (cfg_values),
        .view_next  (view_next)
    );

    sasc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .view_next (view_next),
        .slot_free (slot_free),
        .result    (result)
    );

endmodule

// ===== rtl/core/sasc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Slew controller configuration registers
// Holds slew step, arrival threshold and angle limit; always ready.
// ----------------------------------------------------------------------------
module sasc_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    sasc_cfg_if.sink         cfg,
    output sasc_pkg::cfg_t   cfg_values
);

    sasc_pkg::cfg_t cfg_reg;
    sasc_pkg::cfg_t cfg_next;

    assign cfg.ready  = 1'b1;
    assign cfg_values = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                sasc_pkg::CFG_SLEW_STEP:
                begin
                    cfg_next.slew_step = cfg.data[10:0];
                end
                sasc_pkg::CFG_ARRIVAL_THRESHOLD:
                begin
                    cfg_next.arrival_threshold = cfg.data[9:0];
                end
                sasc_pkg::CFG_ANGLE_LIMIT:
                begin
                    cfg_next.angle_limit = cfg.data[14:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slew_step         <= sasc_pkg::SLEW_STEP_RESET;
            cfg_reg.arrival_threshold <= sasc_pkg::ARRIVAL_THRESHOLD_RESET;
            cfg_reg.angle_limit       <= sasc_pkg::ANGLE_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/sasc_state.sv =====
// ----------------------------------------------------------------------------
// Slew controller state update
// Applies one command to the array state: slew ticks, manual override,
// attitude tracking, the sun offset and the mode, stability and forbid flags.
// ----------------------------------------------------------------------------
module sasc_state (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              update,
    input  sasc_pkg::item_t   item_q,
    input  sasc_pkg::cfg_t    cfg_values,
    output sasc_pkg::view_t   view_next
);

    logic signed [15:0] current_angle_reg, current_angle_next;
    logic signed [15:0] target_angle_reg, target_angle_next;
    logic signed [15:0] sun_offset_reg, sun_offset_next;
    sasc_pkg::status_t  status_reg, status_next;
    logic               motion_enabled_reg, motion_enabled_next;
    logic               override_reg, override_next;
    logic               stability_required_reg, stability_required_next;
    logic               craft_stable_reg, craft_stable_next;
    logic               motion_forbidden_reg, motion_forbidden_next;

    // Tick arithmetic.
    logic signed [16:0] diff;
    logic [16:0]        diff_mag;
    logic signed [17:0] step;
    logic signed [17:0] stepped;
    logic signed [15:0] stepped_sat;

    // Attitude arithmetic.
    logic signed [16:0] rel;
    logic signed [17:0] wrapped;
    logic signed [17:0] aim;
    logic signed [17:0] limit;
    logic signed [15:0] aim_clamped;

    always_comb
    begin
        diff     = 17'(target_angle_reg) - 17'(current_angle_reg);
        diff_mag = (diff < 17'sd0) ? 17'(-diff) : 17'(diff);
        step     = 18'($signed({7'd0, cfg_values.slew_step}));
        stepped  = (diff > 17'sd0) ? 18'(current_angle_reg) + step
                                   : 18'(current_angle_reg) - step;
        if (stepped > sasc_pkg::ANGLE_MAX)
        begin
            stepped_sat = sasc_pkg::ANGLE_MAX[15:0];
        end
        else if (stepped < sasc_pkg::ANGLE_MIN)
        begin
            stepped_sat = sasc_pkg::ANGLE_MIN[15:0];
        end
        else
        begin
            stepped_sat = stepped[15:0];
        end
    end

    always_comb
    begin
        rel = 17'(item_q.angle_value) - 17'(sun_offset_reg);
        // The difference is wrapped once only; the clamp bounds the rest.
        if (18'(rel) > sasc_pkg::HALF_TURN)
        begin
            wrapped = 18'(rel) - sasc_pkg::FULL_TURN;
        end
        else if (18'(rel) < -sasc_pkg::HALF_TURN)
        begin
            wrapped = 18'(rel) + sasc_pkg::FULL_TURN;
        end
        else
        begin
            wrapped = 18'(rel);
        end
        aim   = -wrapped;
        limit = 18'($signed({3'd0, cfg_values.angle_limit}));
        if (aim > limit)
        begin
            aim_clamped = limit[15:0];
        end
        else if (aim < -limit)
        begin
            aim_clamped = 16'(-limit);
        end
        else
        begin
            aim_clamped = aim[15:0];
        end
    end

    always_comb
    begin
        current_angle_next      = current_angle_reg;
        target_angle_next       = target_angle_reg;
        sun_offset_next         = sun_offset_reg;
        status_next             = status_reg;
        motion_enabled_next     = motion_enabled_reg;
        override_next           = override_reg;
        stability_required_next = stability_required_reg;
        craft_stable_next       = craft_stable_reg;
        motion_forbidden_next   = motion_forbidden_reg;

        unique case (item_q.command)
            sasc_pkg::CMD_TICK:
            begin
                if ((status_reg != sasc_pkg::STATUS_RETRACTED) && motion_enabled_reg &&
                    !motion_forbidden_reg)
                begin
                    if (diff_mag <= 17'(cfg_values.arrival_threshold))
                    begin
                        current_angle_next = target_angle_reg;
                        status_next        = sasc_pkg::STATUS_AT_REST;
                    end
                    else
                    begin
                        current_angle_next = stepped_sat;
                        status_next        = sasc_pkg::STATUS_MOVING;
                    end
                end
            end
            sasc_pkg::CMD_MANUAL_ANGLE:
            begin
                status_next         = sasc_pkg::STATUS_AT_REST;
                override_next       = 1'b1;
                target_angle_next   = item_q.angle_value;
                motion_enabled_next = 1'b1;
            end
            sasc_pkg::CMD_CLEAR_OVERRIDE:
            begin
                override_next = 1'b0;
            end
            sasc_pkg::CMD_STABLE_NEEDED:
            begin
                stability_required_next = item_q.flag_value;
            end
            sasc_pkg::CMD_IS_STABLE:
            begin
                craft_stable_next = item_q.flag_value;
            end
            sasc_pkg::CMD_ATTITUDE:
            begin
                if ((status_reg != sasc_pkg::STATUS_RETRACTED) && !override_reg)
                begin
                    if (stability_required_reg && !craft_stable_reg)
                    begin
                        motion_enabled_next = 1'b0;
                    end
                    else
                    begin
                        target_angle_next   = aim_clamped;
                        motion_enabled_next = 1'b1;
                    end
                end
            end
            sasc_pkg::CMD_SUN_OFFSET:
            begin
                sun_offset_next = item_q.angle_value;
            end
            sasc_pkg::CMD_MODE:
            begin
                if ((item_q.mode_value == sasc_pkg::DEPLOY_MODE) &&
                    (item_q.submode_value == sasc_pkg::DEPLOY_SUBMODE))
                begin
                    status_next = sasc_pkg::STATUS_AT_REST;
                end
            end
            sasc_pkg::CMD_FORBID:
            begin
                motion_forbidden_next = item_q.flag_value;
            end
            default:
            begin
                // Undefined commands leave the state alone.
                status_next = status_reg;
            end
        endcase
    end

    assign view_next.angle           = current_angle_next;
    assign view_next.status          = status_next;
    assign view_next.override_active = override_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_angle_reg      <= '0;
            target_angle_reg       <= '0;
            sun_offset_reg         <= '0;
            status_reg             <= sasc_pkg::STATUS_RETRACTED;
            motion_enabled_reg     <= 1'b0;
            override_reg           <= 1'b0;
            stability_required_reg <= 1'b0;
            craft_stable_reg       <= 1'b0;
            motion_forbidden_reg   <= 1'b0;
        end
        else if (update)
        begin
            current_angle_reg      <= current_angle_next;
            target_angle_reg       <= target_angle_next;
            sun_offset_reg         <= sun_offset_next;
            status_reg             <= status_next;
            motion_enabled_reg     <= motion_enabled_next;
            override_reg           <= override_next;
            stability_required_reg <= stability_required_next;
            craft_stable_reg       <= craft_stable_next;
            motion_forbidden_reg   <= motion_forbidden_next;
        end
    end

endmodule

// ===== rtl/core/sasc_out_stage.sv =====
// ----------------------------------------------------------------------------
// Slew controller result stage
// Converts the updated angle to two servo pulse widths and holds the result
// transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module sasc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sasc_pkg::view_t   view_next,
    output logic              slot_free,
    sasc_result_if.source     result
);

    logic               valid_reg;
    logic [11:0]        pwm_first_reg;
    logic [11:0]        pwm_second_reg;
    logic [1:0]         status_reg;
    logic signed [15:0] angle_reg;
    logic               override_reg;

    assign slot_free = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pwm_first_reg  <= sasc_pkg::pulse_width(view_next.angle,
                                                    sasc_pkg::FIRST_PANEL_SKEW);
            pwm_second_reg <= sasc_pkg::pulse_width(view_next.angle,
                                                    sasc_pkg::SECOND_PANEL_SKEW);
            status_reg     <= view_next.status;
            angle_reg      <= view_next.angle;
            override_reg   <= view_next.override_active;
        end
    end

    assign result.valid           = valid_reg;
    assign result.pwm_first       = pwm_first_reg;
    assign result.pwm_second      = pwm_second_reg;
    assign result.array_status    = status_reg;
    assign result.angle_now       = angle_reg;
    assign result.override_active = override_reg;

endmodule
